FILE: hw/rtl/bstat_pkg.sv
// ----------------------------------------------------------------------------
// bstat_pkg: shared constants and types for the block statistics unit
// Field widths, fixed-point scaling and the sequencer state encoding.
// ----------------------------------------------------------------------------
package bstat_pkg;

  // Default sample count limit per block
  localparam int DEF_MAX_SAMPLES = 16;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 20;
  localparam int SD_W     = 20;

  // Fixed-point scaling: mean carries 4 fraction bits, variance is scaled by 2^8
  localparam int MEAN_FRAC = 4;
  localparam int VAR_SHIFT = 8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQR_WAIT,
    S_MEAN,
    S_MEAN_WAIT,
    S_NSQ,
    S_NSQ_WAIT,
    S_SSQ,
    S_SSQ_WAIT,
    S_NN,
    S_NN_WAIT,
    S_VAR,
    S_VAR_WAIT,
    S_ROOT
  } state_t;

endpackage

FILE: hw/rtl/bstat_mul.sv
// ----------------------------------------------------------------------------
// bstat_mul: radix-4 serial multiplier
// Shift-add over 2-bit digits of b, LSB first; stops as soon as b runs out.
// ----------------------------------------------------------------------------
module bstat_mul #(
  parameter int AW = 36,
  parameter int BW = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic               done,
  output logic [AW+BW-1:0]   product
);

  localparam int PW = AW + BW;

  logic          running;
  logic [PW-1:0] ash;
  logic [BW-1:0] bsh;
  logic [PW-1:0] acc;
  logic [PW-1:0] pp;

  // partial product for the current digit
  assign pp = (bsh[0] ? ash : '0) + (bsh[1] ? {ash[PW-2:0], 1'b0} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
      end else if (running && (bsh[BW-1:2] == '0)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ash <= PW'(a);
      bsh <= b;
      acc <= '0;
    end else if (running) begin
      acc <= acc + pp;
      ash <= {ash[PW-3:0], 2'b00};
      bsh <= {2'b00, bsh[BW-1:2]};
    end
  end

  assign product = acc;

endmodule

FILE: hw/rtl/bstat_div.sv
// ----------------------------------------------------------------------------
// bstat_div: restoring serial divider
// One quotient bit per cycle over a DW-bit dividend.
// ----------------------------------------------------------------------------
module bstat_div #(
  parameter int DW = 49,
  parameter int VW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNW = $clog2(DW);

  logic           running;
  logic [CNW-1:0] cnt;
  logic [DW-1:0]  q;
  logic [VW-1:0]  dvs;
  logic [VW-1:0]  rem;
  logic [VW:0]    r2;
  logic [VW:0]    diff;
  logic           ge;

  assign r2   = {rem, q[DW-1]};
  assign ge   = r2 >= {1'b0, dvs};
  assign diff = r2 - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
      end else if (running && (cnt == '0)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q   <= dividend;
      dvs <= divisor;
      rem <= '0;
      cnt <= CNW'(DW - 1);
    end else if (running) begin
      // remainder stays below the divisor, so the top bit drops cleanly
      rem <= ge ? diff[VW-1:0] : r2[VW-1:0];
      q   <= {q[DW-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient = q;

endmodule

FILE: hw/rtl/block_stats_unsigned16_top.sv
// ----------------------------------------------------------------------------
// block_stats_unsigned16_top: mean, min, max and population std deviation
// Serial statistics engine over blocks of unsigned 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive sample and last with start high; the transfer takes
//   place at the rising edge where start is high and busy is low. last marks
//   the final sample of a block.
//   Result channel: done pulses high for one cycle with mean_q4, minimum,
//   maximum, std_dev_q4 and overflow valid in that cycle only. The receiver
//   cannot stall; it must take the result in that cycle.
//   Per sample: each accepted sample is squared by a radix-4 serial
//   multiplier, so busy stays high after the transfer until the square is
//   done and no new sample is taken before then (sooner for small samples,
//   as the square loop stops when the digits run out).
//   Samples beyond MAX_SAMPLES are dropped unsquared and set the overflow
//   flag; a dropped sample with last still closes the block. End of block:
//   the block runs two serial divisions on a dividend of
//   DW = clog2(MAX_SAMPLES+1) + clog2(MAX_SAMPLES) + 40 bits, three serial
//   products and a square root of two radicand bits per step; the divisions,
//   at one quotient bit per cycle, take most of the time up to done.
//   done rises the cycle after the root finishes, busy is already low then,
//   and the statistics are cleared for the next block.
//   Reset: synchronous, active high; clears all running statistics and
//   returns the sequencer to idle with no result pending.
// ----------------------------------------------------------------------------
module block_stats_unsigned16_top #(
  parameter int MAX_SAMPLES = bstat_pkg::DEF_MAX_SAMPLES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bstat_pkg::SAMPLE_W-1:0] sample,
  input  logic                          last,
  output logic                          done,
  output logic [bstat_pkg::MEAN_W-1:0]  mean_q4,
  output logic [bstat_pkg::SAMPLE_W-1:0] minimum,
  output logic [bstat_pkg::SAMPLE_W-1:0] maximum,
  output logic [bstat_pkg::SD_W-1:0]    std_dev_q4,
  output logic                          overflow
);

  // Width plan derived from the sample limit
  localparam int SMW  = bstat_pkg::SAMPLE_W;
  localparam int CW   = $clog2(MAX_SAMPLES + 1);   // sample count
  localparam int LGM  = $clog2(MAX_SAMPLES);
  localparam int SW   = SMW + LGM;                 // running sum
  localparam int SQW  = 2 * SMW + LGM;             // running sum of squares
  localparam int MBW  = SW + (SW % 2);             // multiplier digit operand
  localparam int PW   = SQW + MBW;                 // product
  localparam int NW   = CW + SQW;                  // n*sumsq - sum^2
  localparam int DW   = NW + bstat_pkg::VAR_SHIFT; // scaled variance dividend
  localparam int VW   = 2 * CW;                    // n^2
  localparam int RW2  = DW + (DW % 2);             // radicand, even width
  localparam int RTW  = RW2 / 2;                   // root
  localparam int REMW = RTW + 2;                   // root remainder
  localparam int RCW  = $clog2(RTW);

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

  bstat_pkg::state_t state, state_next;

  // running statistics
  logic [SMW-1:0] running_min;
  logic [SMW-1:0] running_max;
  logic [CW-1:0]  sample_count;
  logic [SW-1:0]  running_sum;
  logic [SQW-1:0] running_sum_squares;
  logic           overflow_seen;
  logic           last_q;

  // end-of-block intermediates
  logic [bstat_pkg::MEAN_W-1:0] mean_hold;
  logic [NW-1:0]  num;
  logic [VW-1:0]  nn;

  // square root unit
  logic [RW2-1:0]  rad;
  logic [RTW-1:0]  root;
  logic [REMW-1:0] rem;
  logic [RCW-1:0]  rcnt;
  logic [REMW+1:0] r2;
  logic [REMW+1:0] trial;
  logic [REMW+1:0] rdiff;
  logic            rge;
  logic [RTW-1:0]  root_next;

  // handshake
  logic accept;
  logic room;

  // serial units
  logic           mul_go, mul_done;
  logic [SQW-1:0] mul_a;
  logic [MBW-1:0] mul_b;
  logic [PW-1:0]  mul_p;
  logic           div_go, div_done;
  logic [DW-1:0]  div_dvd;
  logic [VW-1:0]  div_dvs;
  logic [DW-1:0]  div_q;

  assign accept = start && !busy;
  assign room   = sample_count < MAX_CNT;

  bstat_mul #(
    .AW (SQW),
    .BW (MBW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .go      (mul_go),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  bstat_div #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // One restoring square-root step: bring down two radicand bits per cycle
  assign r2        = {rem, rad[RW2-1 -: 2]};
  assign trial     = {2'b00, root, 2'b01};
  assign rge       = r2 >= trial;
  assign rdiff     = r2 - trial;
  assign root_next = {root[RTW-2:0], rge};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bstat_pkg::S_IDLE: begin
        if (accept) begin
          if (room) begin
            state_next = bstat_pkg::S_SQR_WAIT;
          end else if (last) begin
            // dropped sample still closes the block
            state_next = bstat_pkg::S_MEAN;
          end
        end
      end
      bstat_pkg::S_SQR_WAIT: begin
        if (mul_done) begin
          state_next = last_q ? bstat_pkg::S_MEAN : bstat_pkg::S_IDLE;
        end
      end
      bstat_pkg::S_MEAN:      state_next = bstat_pkg::S_MEAN_WAIT;
      bstat_pkg::S_MEAN_WAIT: if (div_done) state_next = bstat_pkg::S_NSQ;
      bstat_pkg::S_NSQ:       state_next = bstat_pkg::S_NSQ_WAIT;
      bstat_pkg::S_NSQ_WAIT:  if (mul_done) state_next = bstat_pkg::S_SSQ;
      bstat_pkg::S_SSQ:       state_next = bstat_pkg::S_SSQ_WAIT;
      bstat_pkg::S_SSQ_WAIT:  if (mul_done) state_next = bstat_pkg::S_NN;
      bstat_pkg::S_NN:        state_next = bstat_pkg::S_NN_WAIT;
      bstat_pkg::S_NN_WAIT:   if (mul_done) state_next = bstat_pkg::S_VAR;
      bstat_pkg::S_VAR:       state_next = bstat_pkg::S_VAR_WAIT;
      bstat_pkg::S_VAR_WAIT:  if (div_done) state_next = bstat_pkg::S_ROOT;
      bstat_pkg::S_ROOT:      if (rcnt == '0) state_next = bstat_pkg::S_IDLE;
      default:                state_next = bstat_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: unit launches and operand selection
  always_comb begin
    busy    = (state != bstat_pkg::S_IDLE);
    mul_go  = 1'b0;
    mul_a   = SQW'(sample);
    mul_b   = MBW'(sample);
    div_go  = 1'b0;
    div_dvd = DW'({running_sum, {bstat_pkg::MEAN_FRAC{1'b0}}});
    div_dvs = VW'(sample_count);
    unique case (state)
      bstat_pkg::S_IDLE: begin
        // square the sample while the cheap stats update in parallel
        mul_go = accept && room;
      end
      bstat_pkg::S_MEAN: begin
        div_go = 1'b1;
      end
      bstat_pkg::S_NSQ: begin
        mul_go = 1'b1;
        mul_a  = running_sum_squares;
        mul_b  = MBW'(sample_count);
      end
      bstat_pkg::S_SSQ: begin
        mul_go = 1'b1;
        mul_a  = SQW'(running_sum);
        mul_b  = MBW'(running_sum);
      end
      bstat_pkg::S_NN: begin
        mul_go = 1'b1;
        mul_a  = SQW'(sample_count);
        mul_b  = MBW'(sample_count);
      end
      bstat_pkg::S_VAR: begin
        div_go  = 1'b1;
        div_dvd = {num, {bstat_pkg::VAR_SHIFT{1'b0}}};
        div_dvs = nn;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bstat_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Running statistics and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      running_min         <= '1;
      running_max         <= '0;
      sample_count        <= '0;
      running_sum         <= '0;
      running_sum_squares <= '0;
      overflow_seen       <= 1'b0;
      last_q              <= 1'b0;
      done                <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        last_q <= last;
        if (room) begin
          if (sample < running_min) running_min <= sample;
          if (sample > running_max) running_max <= sample;
          running_sum  <= running_sum + SW'(sample);
          sample_count <= sample_count + 1'b1;
        end else begin
          // block too long: drop the sample, flag it
          overflow_seen <= 1'b1;
        end
      end
      if (state == bstat_pkg::S_SQR_WAIT && mul_done) begin
        running_sum_squares <= running_sum_squares + mul_p[SQW-1:0];
      end
      if (state == bstat_pkg::S_ROOT && rcnt == '0) begin
        // result out, clear for the next block
        done                <= 1'b1;
        running_min         <= '1;
        running_max         <= '0;
        sample_count        <= '0;
        running_sum         <= '0;
        running_sum_squares <= '0;
        overflow_seen       <= 1'b0;
      end
    end
  end

  // End-of-block datapath
  always_ff @(posedge clk) begin
    if (state == bstat_pkg::S_MEAN_WAIT && div_done) begin
      mean_hold <= div_q[bstat_pkg::MEAN_W-1:0];
    end
    if (state == bstat_pkg::S_NSQ_WAIT && mul_done) begin
      num <= mul_p[NW-1:0];
    end
    if (state == bstat_pkg::S_SSQ_WAIT && mul_done) begin
      // sum^2 never exceeds n*sumsq
      num <= num - mul_p[NW-1:0];
    end
    if (state == bstat_pkg::S_NN_WAIT && mul_done) begin
      nn <= mul_p[VW-1:0];
    end
    if (state == bstat_pkg::S_VAR_WAIT && div_done) begin
      rad  <= RW2'(div_q);
      root <= '0;
      rem  <= '0;
      rcnt <= RCW'(RTW - 1);
    end
    if (state == bstat_pkg::S_ROOT) begin
      rad  <= {rad[RW2-3:0], 2'b00};
      root <= root_next;
      rem  <= rge ? rdiff[REMW-1:0] : r2[REMW-1:0];
      rcnt <= rcnt - 1'b1;
      if (rcnt == '0) begin
        mean_q4    <= mean_hold;
        minimum    <= running_min;
        maximum    <= running_max;
        std_dev_q4 <= root_next[bstat_pkg::SD_W-1:0];
        overflow   <= overflow_seen;
      end
    end
  end

endmodule

FILE: hw/rtl/bstat_chk.sv
// ----------------------------------------------------------------------------
// bstat_chk: port-level checks for the block statistics unit
// Watches the command and result ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module bstat_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           last,
  input logic                           done,
  input logic [bstat_pkg::SAMPLE_W-1:0] minimum,
  input logic [bstat_pkg::SAMPLE_W-1:0] maximum
);

  // a result is a single-cycle pulse
  a_done_pulse : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // the unit is idle in the cycle its result shows
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // a transfer without last cannot yield a result in the next cycle
  a_no_early_result : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last) |=> !done)
    else $error("result after a non-final sample");

  // minimum never exceeds maximum, as every block holds at least one sample
  a_min_le_max : assert property (@(posedge clk) disable iff (rst)
    done |-> (minimum <= maximum))
    else $error("minimum above maximum");

endmodule

bind block_stats_unsigned16_top bstat_chk u_bstat_chk (.*);

FILE: tb/block_stats_unsigned16_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_stats_unsigned16_top_tb: self-checking bench for the block statistics unit
// Streams blocks of 16-bit samples through the start/busy port. A local model
// tracks min, max, count, sum and sum of squares and predicts each block
// result. The bench compares every result on done field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module block_stats_unsigned16_top_tb;

  localparam int SAMPLE_W     = bstat_pkg::SAMPLE_W;
  localparam int MEAN_W       = bstat_pkg::MEAN_W;
  localparam int SD_W         = bstat_pkg::SD_W;
  localparam int MEAN_FRAC    = bstat_pkg::MEAN_FRAC;
  localparam int VAR_SHIFT    = bstat_pkg::VAR_SHIFT;
  localparam int MAX_N        = bstat_pkg::DEF_MAX_SAMPLES;
  localparam int RANDOM_ITEMS = 1130;
  localparam int DRAIN_CYCLES = 250;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic [MEAN_W-1:0]   mean_q4;
    logic [SAMPLE_W-1:0] minimum;
    logic [SAMPLE_W-1:0] maximum;
    logic [SD_W-1:0]     std_dev_q4;
    logic                overflow;
  } block_stats_t;

  // Sample value patterns for the random blocks
  typedef enum int {MIX_FULL, MIX_LOW, MIX_HIGH, MIX_CLUSTER} sample_mix_t;

  logic                clk    = 1'b0;
  logic                rst    = 1'b1;
  logic                start  = 1'b0;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                last   = 1'b0;
  logic                busy;
  logic                done;
  logic [MEAN_W-1:0]   mean_q4;
  logic [SAMPLE_W-1:0] minimum;
  logic [SAMPLE_W-1:0] maximum;
  logic [SD_W-1:0]     std_dev_q4;
  logic                overflow;

  // Running statistics of the open block, as the model sees them
  logic [SAMPLE_W-1:0] acc_min;
  logic [SAMPLE_W-1:0] acc_max;
  int unsigned         acc_count;
  longint unsigned     acc_sum;
  longint unsigned     acc_sumsq;
  logic                acc_overflow;

  block_stats_t pending_stats[$];
  int           mismatches  = 0;
  int           cycle_count = 0;

  block_stats_unsigned16_top #(
    .MAX_SAMPLES(MAX_N)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .sample    (sample),
    .last      (last),
    .done      (done),
    .mean_q4   (mean_q4),
    .minimum   (minimum),
    .maximum   (maximum),
    .std_dev_q4(std_dev_q4),
    .overflow  (overflow)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Clear the model's block state, same as the block after reset or a result
  function automatic void clear_block();
    acc_min      = '1;
    acc_max      = '0;
    acc_count    = 0;
    acc_sum      = 0;
    acc_sumsq    = 0;
    acc_overflow = 1'b0;
  endfunction

  // Floor square root, one result bit at a time from the top
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned cand;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= v) root = cand;
    end
    return root;
  endfunction

  // Fold one accepted sample into the model; queue a result on the last one
  function automatic void accumulate_sample(logic [SAMPLE_W-1:0] s, logic l);
    block_stats_t    r;
    longint unsigned n;
    longint unsigned spread;
    if (acc_count < MAX_N) begin
      if (s < acc_min) acc_min = s;
      if (s > acc_max) acc_max = s;
      acc_sum   += s;
      acc_sumsq += longint'(s) * longint'(s);
      acc_count++;
    end else begin
      // block too long: drop the sample, only flag it
      acc_overflow = 1'b1;
    end
    if (l) begin
      n            = acc_count;
      spread       = n * acc_sumsq - acc_sum * acc_sum;
      r.mean_q4    = MEAN_W'((acc_sum << MEAN_FRAC) / n);
      r.minimum    = acc_min;
      r.maximum    = acc_max;
      r.std_dev_q4 = SD_W'(floor_sqrt((spread << VAR_SHIFT) / (n * n)));
      r.overflow   = acc_overflow;
      pending_stats.push_back(r);
      clear_block();
    end
  endfunction

  // Offer one sample and hold it until the transfer. Leave start high on
  // return so that a back-to-back sample needs no second write in this step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic l,
                             input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    sample <= s;
    last   <= l;
    do @(posedge clk); while (busy);
    accumulate_sample(s, l);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // One-sample blocks at both ends of the range: deviation must be zero
  task automatic test_single_sample_blocks();
    send_sample(16'h0000, 1'b1, 1'b0);
    send_sample(16'hFFFF, 1'b1, 1'b0);
  endtask

  // Widest possible spread: the two extremes in one block
  task automatic test_extreme_spread();
    send_sample(16'h0000, 1'b0, 1'b0);
    send_sample(16'hFFFF, 1'b1, 1'b1);
  endtask

  // Full block of maxima, then two dropped zeros with last on a dropped one:
  // sum and sum of squares peak, min must stay at the maximum, overflow set
  task automatic test_block_overflow();
    for (int i = 0; i < MAX_N; i++) send_sample(16'hFFFF, 1'b0, i[0]);
    send_sample(16'h0000, 1'b0, 1'b0);
    send_sample(16'h0000, 1'b1, 1'b1);
  endtask

  // Random blocks, mostly within the limit, some past it
  task automatic test_random_blocks();
    int                  sent;
    int                  len;
    bit                  burst;
    sample_mix_t         mix;
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] s;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len   = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_N + 1, MAX_N + 8)
                                          : $urandom_range(1, MAX_N);
      mix   = sample_mix_t'($urandom_range(0, 3));
      burst = ($urandom_range(0, 3) == 0);
      base  = SAMPLE_W'($urandom);
      for (int i = 0; i < len; i++) begin
        case (mix)
          MIX_FULL:    s = SAMPLE_W'($urandom);
          MIX_LOW:     s = SAMPLE_W'($urandom_range(0, 15));
          MIX_HIGH:    s = 16'hFFFF - SAMPLE_W'($urandom_range(0, 15));
          default:     s = base ^ SAMPLE_W'($urandom_range(0, 3));
        endcase
        send_sample(s, i == len - 1, burst);
      end
      sent += len;
    end
  endtask

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    block_stats_t want;
    if (!rst && done) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected result, expected none actual mean %0d", $time, mean_q4);
        mismatches++;
      end else begin
        want = pending_stats.pop_front();
        check_field("mean_q4", want.mean_q4, mean_q4);
        check_field("minimum", want.minimum, minimum);
        check_field("maximum", want.maximum, maximum);
        check_field("std_dev_q4", want.std_dev_q4, std_dev_q4);
        check_field("overflow", want.overflow, overflow);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[block_stats_unsigned16_top] ERROR");
      $finish;
    end
  end

  initial begin
    clear_block();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_sample_blocks();
    test_extreme_spread();
    test_block_overflow();
    test_random_blocks();

    // Drop start, wait out the last result, then let the block settle
    start <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[block_stats_unsigned16_top] OK");
    end else begin
      $display("[block_stats_unsigned16_top] ERROR");
    end
    $finish;
  end

endmodule
